// ===== rtl/core/ccp_pkg.sv =====
// Package for the colour text parser: field widths and the result record.
// No dependencies; imported by ccp_parser and css_color_text_parser.

package ccp_pkg;

    localparam int CH_W    = 8;
    localparam int MODE_W  = 2;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 2;

    typedef struct packed {
        logic [COUNT_W-1:0] matched_count;
        logic [VAL_W-1:0]   first_value;
        logic [VAL_W-1:0]   second_value;
        logic [VAL_W-1:0]   third_value;
        logic               first_written;
        logic               second_written;
        logic               third_written;
    } ccp_result_t;

endpackage

// ===== rtl/core/ccp_parser.sv =====
// Parse state and per-byte update for the colour text parser.
// Depends on ccp_pkg for widths and the result record.

module ccp_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ccp_pkg::MODE_W-1:0]  cfg_wr_data,
    input  logic                        step_en,
    input  logic [ccp_pkg::CH_W-1:0]    ch,
    output ccp_pkg::ccp_result_t        result
);
    import ccp_pkg::*;

    typedef enum logic [1:0] {PH_PREFIX, PH_PRE, PH_DIGITS, PH_AFTER} phase_t;
    typedef enum logic [1:0] {OC_UNDECIDED, OC_MATCHED, OC_FAILED} outcome_t;

    localparam logic [MODE_W-1:0] MODE_HEX6 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEX3 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGB  = 2'd2;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2c;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2b;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [3:0]      POS_MAX   = 4'd15;
    localparam logic [1:0]      IDX_NONE  = 2'd3;

    function automatic logic [4:0] hex_val(input logic [CH_W-1:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
        else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
        else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
        return v;
    endfunction

    function automatic logic [CH_W-1:0] prefix_char(input logic [1:0] p);
        logic [CH_W-1:0] c;
        case (p)
            2'd0:    c = 8'h72;
            2'd1:    c = 8'h67;
            2'd2:    c = 8'h62;
            default: c = 8'h28;
        endcase
        return c;
    endfunction

    logic [MODE_W-1:0] mode_reg,  mode_next;
    logic [3:0]        pos_reg,   pos_next;
    phase_t            phase_reg, phase_next;
    logic [1:0]        idx_reg,   idx_next;
    logic [VAL_W-1:0]  acc_reg,   acc_next;
    logic              neg_reg,   neg_next;
    logic              seen_reg,  seen_next;
    logic [VAL_W-1:0]  vals_reg [3];
    logic [VAL_W-1:0]  vals_next [3];
    logic [2:0]        wr_reg,    wr_next;
    outcome_t          oc_reg,    oc_next;

    always_comb begin
        logic [4:0]       hd;
        logic             dig;
        logic [VAL_W-1:0] dval;
        logic [VAL_W-1:0] sval;
        logic             do_after;
        logic             st_en;
        logic [1:0]       st_idx;
        logic [VAL_W-1:0] st_val;
        logic [1:0]       hidx;
        logic [VAL_W-1:0] fin_vals [3];
        logic [2:0]       fin_wr;

        hd       = hex_val(ch);
        dig      = ch inside {[8'h30:8'h39]};
        dval     = VAL_W'(ch - CH_ZERO);
        sval     = neg_reg ? (VAL_W'(0) - acc_reg) : acc_reg;
        do_after = 1'b0;
        st_en    = 1'b0;
        st_idx   = idx_reg;
        st_val   = '0;
        hidx     = '0;

        mode_next  = mode_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        vals_next  = vals_reg;
        wr_next    = wr_reg;
        oc_next    = oc_reg;

        // close an open decimal when the string ends
        fin_vals = vals_reg;
        fin_wr   = wr_reg;
        if (oc_reg == OC_UNDECIDED && mode_reg == MODE_RGB && idx_reg != IDX_NONE) begin
            if (phase_reg == PH_PRE) begin
                fin_vals[idx_reg] = '0;
                fin_wr[idx_reg]   = 1'b1;
            end else if (phase_reg == PH_DIGITS) begin
                fin_vals[idx_reg] = seen_reg ? sval : '0;
                fin_wr[idx_reg]   = 1'b1;
            end
        end
        result.matched_count  = (oc_reg == OC_MATCHED) ? 2'd3 : 2'd0;
        result.first_value    = fin_wr[0] ? fin_vals[0] : '0;
        result.second_value   = fin_wr[1] ? fin_vals[1] : '0;
        result.third_value    = fin_wr[2] ? fin_vals[2] : '0;
        result.first_written  = fin_wr[0];
        result.second_written = fin_wr[1];
        result.third_written  = fin_wr[2];

        if (cfg_wr_en || (step_en && ch == CH_NUL)) begin
            if (cfg_wr_en) begin
                mode_next = cfg_wr_data;
            end
            pos_next   = '0;
            phase_next = PH_PREFIX;
            idx_next   = '0;
            acc_next   = '0;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            wr_next    = '0;
            oc_next    = OC_UNDECIDED;
        end else if (step_en) begin
            if (oc_reg == OC_UNDECIDED) begin
                case (mode_reg)
                    MODE_HEX6: begin
                        if (pos_reg == 4'd0) begin
                            if (ch != CH_HASH) oc_next = OC_FAILED;
                        end else if (hd[4] || pos_reg > 4'd6) begin
                            oc_next = OC_FAILED;
                        end else if (pos_reg[0]) begin
                            acc_next = VAL_W'(hd[3:0]);
                        end else begin
                            st_en  = 1'b1;
                            st_idx = pos_reg[2:1] - 2'd1;
                            st_val = {acc_reg[VAL_W-5:0], hd[3:0]};
                            if (pos_reg == 4'd6) oc_next = OC_MATCHED;
                        end
                    end
                    MODE_HEX3: begin
                        if (pos_reg == 4'd0) begin
                            if (ch != CH_HASH) oc_next = OC_FAILED;
                        end else if (hd[4] || pos_reg > 4'd3) begin
                            oc_next = OC_FAILED;
                        end else begin
                            hidx            = pos_reg[1:0] - 2'd1;
                            vals_next[hidx] = VAL_W'(hd[3:0]);
                            if (pos_reg == 4'd3) begin
                                wr_next = 3'b111;
                                oc_next = OC_MATCHED;
                            end
                        end
                    end
                    MODE_RGB: begin
                        case (phase_reg)
                            PH_PREFIX: begin
                                if (pos_reg > 4'd3 || ch != prefix_char(pos_reg[1:0])) begin
                                    oc_next = OC_FAILED;
                                end else if (pos_reg == 4'd3) begin
                                    phase_next = PH_PRE;
                                    idx_next   = '0;
                                end
                            end
                            PH_PRE: begin
                                if (!(ch inside {8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0c, 8'h0b})) begin
                                    neg_next  = (ch == CH_MINUS);
                                    acc_next  = '0;
                                    seen_next = 1'b0;
                                    if (ch == CH_PLUS || ch == CH_MINUS) begin
                                        phase_next = PH_DIGITS;
                                    end else if (dig) begin
                                        acc_next   = dval;
                                        seen_next  = 1'b1;
                                        phase_next = PH_DIGITS;
                                    end else begin
                                        st_en   = 1'b1;
                                        oc_next = OC_FAILED;
                                    end
                                end
                            end
                            PH_DIGITS: begin
                                if (dig) begin
                                    acc_next  = (acc_reg << 3) + (acc_reg << 1) + dval;
                                    seen_next = 1'b1;
                                end else if (!seen_reg) begin
                                    st_en   = 1'b1;
                                    oc_next = OC_FAILED;
                                end else begin
                                    st_en      = 1'b1;
                                    st_val     = sval;
                                    phase_next = PH_AFTER;
                                    do_after   = 1'b1;
                                end
                            end
                            default: begin
                                do_after = 1'b1;
                            end
                        endcase
                        if (do_after && ch != CH_SPACE) begin
                            if (idx_reg < 2'd2 && ch == CH_COMMA) begin
                                idx_next   = idx_reg + 2'd1;
                                phase_next = PH_PRE;
                            end else if (idx_reg == 2'd2 && ch == CH_RPAREN) begin
                                oc_next = OC_MATCHED;
                            end else begin
                                oc_next = OC_FAILED;
                            end
                        end
                    end
                    default: begin
                        oc_next = OC_FAILED;
                    end
                endcase
                if (st_en && st_idx != IDX_NONE) begin
                    vals_next[st_idx] = st_val;
                    wr_next[st_idx]   = 1'b1;
                end
            end
            if (pos_reg != POS_MAX) pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_HEX6;
            pos_reg   <= '0;
            phase_reg <= PH_PREFIX;
            idx_reg   <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            wr_reg    <= '0;
            oc_reg    <= OC_UNDECIDED;
        end else begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            wr_reg    <= wr_next;
            oc_reg    <= oc_next;
        end
    end

    always_ff @(posedge aclk) begin
        vals_reg <= vals_next;
    end

endmodule

// ===== rtl/core/css_color_text_parser.sv =====
// Top level of the colour text parser: input register, parse core, result register.
// Depends on ccp_pkg and ccp_parser.
//
// Usage: text bytes arrive on s_ch with s_valid/s_ready, one per transfer.
// A zero byte ends the string; it yields one result transfer on the m_
// channel carrying the match count and the three component values and
// written flags. Other bytes yield nothing. cfg_wr_en/cfg_wr_data select
// the format (six hex, three hex, rgb triple) and clear any parse in
// progress; write it only while the block is idle.
// Throughput: one byte per cycle, unless a zero byte must wait for the result register.
// Each byte is held in an input register and goes through the parse update from there;
// the result for a zero byte is held in the output register, which drives m_valid.
// Stall: a result waits in the output register while m_ready is low; bytes
// that are not zero keep flowing; a second zero byte waits in the input
// register and s_ready drops until the result is taken.
// Reset: aresetn low clears both valid flags, the format (six hex) and the
// parse state.

module css_color_text_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ccp_pkg::MODE_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ccp_pkg::CH_W-1:0]      s_ch,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ccp_pkg::COUNT_W-1:0]   m_matched_count,
    output logic [ccp_pkg::VAL_W-1:0]     m_first_value,
    output logic [ccp_pkg::VAL_W-1:0]     m_second_value,
    output logic [ccp_pkg::VAL_W-1:0]     m_third_value,
    output logic                          m_first_written,
    output logic                          m_second_written,
    output logic                          m_third_written
);
    import ccp_pkg::*;

    logic            in_vld_reg;
    logic [CH_W-1:0] in_ch_reg;
    logic            out_vld_reg;
    ccp_result_t     res_reg;
    ccp_result_t     core_result;
    logic            in_nul;
    logic            advance;

    assign in_nul  = (in_ch_reg == '0);
    assign advance = in_vld_reg && (!in_nul || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    ccp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .ch          (in_ch_reg),
        .result      (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) in_vld_reg <= s_valid;
            if (advance && in_nul) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_ch_reg <= s_ch;
        if (advance && in_nul) res_reg <= core_result;
    end

    assign m_valid          = out_vld_reg;
    assign m_matched_count  = res_reg.matched_count;
    assign m_first_value    = res_reg.first_value;
    assign m_second_value   = res_reg.second_value;
    assign m_third_value    = res_reg.third_value;
    assign m_first_written  = res_reg.first_written;
    assign m_second_written = res_reg.second_written;
    assign m_third_written  = res_reg.third_written;

    a_count_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_matched_count == 2'd0 || m_matched_count == 2'd3))
        else $error("match count neither zero nor three");

    a_match_all_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_matched_count == 2'd3)
            |-> (m_first_written && m_second_written && m_third_written))
        else $error("match reported with a component unwritten");

    a_unwritten_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_first_written || m_first_value == '0)
                  && (m_second_written || m_second_value == '0)
                  && (m_third_written || m_third_value == '0)))
        else $error("unwritten component carries a value");

    a_stall_holds_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_ch_reg)))
        else $error("stalled byte lost from input register");

endmodule

// ===== bench/css_color_text_parser_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for css_color_text_parser: directed colour strings, then random strings.
// Depends on ccp_pkg and the css_color_text_parser RTL; holds its own parse predictor.

module css_color_text_parser_test;

    import ccp_pkg::*;

    localparam logic [1:0] MODE_HEX6 = 2'd0;
    localparam logic [1:0] MODE_HEX3 = 2'd1;
    localparam logic [1:0] MODE_RGB  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [31:0] RGB_OPEN  = "rgb(";
    localparam logic [47:0] SPACE_SET = {8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0c, 8'h0b};
    localparam int CFG_SETTLE  = 4;
    localparam int END_HOLD    = 8;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {PH_PREFIX, PH_PRE, PH_DIGITS, PH_AFTER} rgb_phase_e;
    typedef enum logic [1:0] {UNDECIDED, MATCHED, FAILED} verdict_e;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [MODE_W-1:0]  cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [CH_W-1:0]    s_ch;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [COUNT_W-1:0] m_matched_count;
    logic [VAL_W-1:0]   m_first_value;
    logic [VAL_W-1:0]   m_second_value;
    logic [VAL_W-1:0]   m_third_value;
    logic               m_first_written;
    logic               m_second_written;
    logic               m_third_written;

    css_color_text_parser uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ch             (s_ch),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_matched_count  (m_matched_count),
        .m_first_value    (m_first_value),
        .m_second_value   (m_second_value),
        .m_third_value    (m_third_value),
        .m_first_written  (m_first_written),
        .m_second_written (m_second_written),
        .m_third_written  (m_third_written)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    ccp_result_t colour_q[$];
    logic [7:0]  text_buf[$];
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          mismatches  = 0;
    int          stall_cycles = 0;

    logic [1:0]  fmt_mode;
    logic [3:0]  char_pos;
    rgb_phase_e  phase;
    logic [1:0]  comp_idx;
    logic [31:0] acc;
    bit          negative;
    bit          digit_seen;
    logic [31:0] comp_val [3];
    logic [2:0]  wr_flags;
    verdict_e    verdict;

    string       dir_text[$];
    logic [1:0]  dir_mode[$];
    bit          dir_typed[$];
    ccp_result_t dir_want[$];

    function automatic void clear_parse();
        char_pos   = '0;
        phase      = PH_PREFIX;
        comp_idx   = '0;
        acc        = '0;
        negative   = 1'b0;
        digit_seen = 1'b0;
        comp_val   = '{default: '0};
        wr_flags   = '0;
        verdict    = UNDECIDED;
    endfunction

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return 5'd16;
    endfunction

    function automatic bit is_space6(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic void store_comp(input logic [1:0] idx, input logic [31:0] v);
        if (idx < 2'd3) begin
            comp_val[idx] = v;
            wr_flags[idx] = 1'b1;
        end
    endfunction

    function automatic void commit_decimal();
        store_comp(comp_idx, negative ? 32'd0 - acc : acc);
    endfunction

    function automatic void after_decimal(input logic [7:0] c);
        if (c == " ") return;
        if (comp_idx < 2'd2 && c == ",") begin
            comp_idx++;
            phase = PH_PRE;
        end else if (comp_idx == 2'd2 && c == ")") begin
            verdict = MATCHED;
        end else begin
            verdict = FAILED;
        end
    endfunction

    function automatic void rgb_byte(input logic [7:0] c);
        bit dig;
        dig = c >= "0" && c <= "9";
        case (phase)
            PH_PREFIX: begin
                if (char_pos > 4'd3 || c != RGB_OPEN[8*(3-char_pos[1:0]) +: 8]) begin
                    verdict = FAILED;
                end else if (char_pos == 4'd3) begin
                    phase    = PH_PRE;
                    comp_idx = '0;
                end
            end
            PH_PRE: begin
                if (!is_space6(c)) begin
                    negative   = (c == "-");
                    acc        = '0;
                    digit_seen = 1'b0;
                    if (c == "+" || c == "-") begin
                        phase = PH_DIGITS;
                    end else if (dig) begin
                        acc        = 32'(c - "0");
                        digit_seen = 1'b1;
                        phase      = PH_DIGITS;
                    end else begin
                        store_comp(comp_idx, '0);
                        verdict = FAILED;
                    end
                end
            end
            PH_DIGITS: begin
                if (dig) begin
                    acc        = acc * 32'd10 + 32'(c - "0");
                    digit_seen = 1'b1;
                end else if (!digit_seen) begin
                    store_comp(comp_idx, '0);
                    verdict = FAILED;
                end else begin
                    commit_decimal();
                    phase = PH_AFTER;
                    after_decimal(c);
                end
            end
            default: after_decimal(c);
        endcase
    endfunction

    function automatic void hex6_byte(input logic [7:0] c);
        logic [4:0] h;
        h = nibble_of(c);
        if (char_pos == 4'd0) begin
            if (c != "#") verdict = FAILED;
        end else if (h > 5'd15 || char_pos > 4'd6) begin
            verdict = FAILED;
        end else if (char_pos[0]) begin
            acc = 32'(h);
        end else begin
            store_comp(2'(char_pos / 2 - 1), (acc << 4) | 32'(h));
            if (char_pos == 4'd6) verdict = MATCHED;
        end
    endfunction

    function automatic void hex3_byte(input logic [7:0] c);
        logic [4:0] h;
        h = nibble_of(c);
        if (char_pos == 4'd0) begin
            if (c != "#") verdict = FAILED;
        end else if (h > 5'd15 || char_pos > 4'd3) begin
            verdict = FAILED;
        end else begin
            comp_val[char_pos - 1] = 32'(h);
            if (char_pos == 4'd3) begin
                wr_flags = 3'b111;
                verdict  = MATCHED;
            end
        end
    endfunction

    // Advance the parse by one byte; a zero byte yields the result and clears the parse.
    function automatic bit parse_byte(input logic [7:0] c, output ccp_result_t res);
        res = '0;
        if (c == 8'd0) begin
            if (verdict == UNDECIDED) begin
                if (fmt_mode == MODE_RGB) begin
                    if (phase == PH_PRE) begin
                        store_comp(comp_idx, '0);
                    end else if (phase == PH_DIGITS) begin
                        if (digit_seen) commit_decimal();
                        else store_comp(comp_idx, '0);
                    end
                end
                verdict = FAILED;
            end
            res.matched_count  = (verdict == MATCHED) ? 2'd3 : 2'd0;
            res.first_value    = wr_flags[0] ? comp_val[0] : '0;
            res.second_value   = wr_flags[1] ? comp_val[1] : '0;
            res.third_value    = wr_flags[2] ? comp_val[2] : '0;
            res.first_written  = wr_flags[0];
            res.second_written = wr_flags[1];
            res.third_written  = wr_flags[2];
            clear_parse();
            return 1'b1;
        end
        if (verdict == UNDECIDED) begin
            case (fmt_mode)
                MODE_HEX6: hex6_byte(c);
                MODE_HEX3: hex3_byte(c);
                MODE_RGB:  rgb_byte(c);
                default:   verdict = FAILED;
            endcase
        end
        if (char_pos < 4'd15) char_pos++;
        return 1'b0;
    endfunction

    task automatic transfer_byte(input logic [7:0] c);
        ccp_result_t res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (parse_byte(c, res)) colour_q.push_back(res);
    endtask

    task automatic send_text();
        foreach (text_buf[k]) transfer_byte(text_buf[k]);
        transfer_byte(8'd0);
    endtask

    task automatic set_format(input logic [1:0] m);
        s_valid <= 1'b0;
        while (colour_q.size() != 0) @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fmt_mode = m;
        clear_parse();
    endtask

    task automatic add_row(input logic [1:0] m, input string t, input bit typed,
                           input ccp_result_t want);
        dir_mode.push_back(m);
        dir_text.push_back(t);
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endtask

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    function automatic void push_bytes(input string t);
        for (int k = 0; k < t.len(); k++) text_buf.push_back(t[k]);
    endfunction

    // Build one random string: mostly well formed for the mode (any format for MODE_NONE), some broken, some noise.
    function automatic void build_text(input logic [1:0] m);
        int kind;
        int form;
        int n;
        int r;
        text_buf.delete();
        kind = $urandom_range(0, 9);
        form = (m == MODE_NONE) ? $urandom_range(0, 2) : int'(m);
        if (kind == 0) begin
            repeat ($urandom_range(0, 10)) text_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        if (form == 2) begin
            push_bytes("rgb(");
            for (int k = 0; k < 3; k++) begin
                repeat ($urandom_range(0, 2))
                    text_buf.push_back(SPACE_SET[8*$urandom_range(0, 5) +: 8]);
                r = $urandom_range(0, 5);
                if (r == 0) text_buf.push_back("+");
                else if (r == 1) text_buf.push_back("-");
                n = ($urandom_range(0, 19) < 15) ? $urandom_range(1, 3) : $urandom_range(4, 12);
                repeat (n) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
                repeat ($urandom_range(0, 1)) text_buf.push_back(" ");
                text_buf.push_back(k < 2 ? "," : ")");
            end
        end else begin
            text_buf.push_back("#");
            repeat (form == 0 ? 6 : 3) text_buf.push_back(hex_char());
        end
        if (kind <= 3) begin
            case ($urandom_range(0, 2))
                0: begin
                    n = $urandom_range(0, text_buf.size() - 1);
                    while (text_buf.size() > n) void'(text_buf.pop_back());
                end
                1: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
                default: repeat ($urandom_range(1, 4))
                       text_buf.push_back(8'($urandom_range(1, 255)));
            endcase
        end
    endfunction

    always @(posedge aclk) begin
        ccp_result_t got;
        ccp_result_t want;
        got = {m_matched_count, m_first_value, m_second_value, m_third_value,
               m_first_written, m_second_written, m_third_written};
        if (aresetn && m_valid && m_ready) begin
            if (colour_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer: %p", got);
            end else begin
                want = colour_q.pop_front();
                if (got.matched_count  !== want.matched_count  ||
                    got.first_value    !== want.first_value    ||
                    got.second_value   !== want.second_value   ||
                    got.third_value    !== want.third_value    ||
                    got.first_written  !== want.first_written  ||
                    got.second_written !== want.second_written ||
                    got.third_written  !== want.third_written) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch at %0t", $time);
                        $display("  expected count %0d values %h %h %h written %b%b%b",
                                 want.matched_count, want.first_value, want.second_value,
                                 want.third_value, want.first_written, want.second_written,
                                 want.third_written);
                        $display("  actual   count %0d values %h %h %h written %b%b%b",
                                 got.matched_count, got.first_value, got.second_value,
                                 got.third_value, got.first_written, got.second_written,
                                 got.third_written);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles == STALL_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int sent;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_ch        <= '0;
        fmt_mode = MODE_HEX6;
        clear_parse();

        add_row(MODE_HEX6, "", 1, '0);
        add_row(MODE_HEX6, "#00ff7F", 1, '{2'd3, 32'h00, 32'hff, 32'h7f, 1'b1, 1'b1, 1'b1});
        add_row(MODE_HEX6, "#12", 1, '{2'd0, 32'h12, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0});
        add_row(MODE_HEX6, "x", 1, '0);
        add_row(MODE_HEX6, "#1g", 0, '0);
        add_row(MODE_HEX6, "#abcdef0123456789xyz", 0, '0);
        add_row(MODE_HEX6, "\377\200#", 0, '0);
        add_row(MODE_HEX3, "#fA0", 1, '{2'd3, 32'hf, 32'ha, 32'h0, 1'b1, 1'b1, 1'b1});
        add_row(MODE_HEX3, "#ab", 1, '0);
        add_row(MODE_HEX3, "#abcd", 0, '0);
        add_row(MODE_HEX3, "#", 0, '0);
        add_row(MODE_RGB, "rgb(255, 0, -1)", 1,
                '{2'd3, 32'd255, 32'd0, 32'hffffffff, 1'b1, 1'b1, 1'b1});
        add_row(MODE_RGB, "rgb(\011\012\015\014\013 +7 ,  8 , 9 )", 0, '0);
        add_row(MODE_RGB, "rgb(4294967296,4294967295,-4294967295)", 0, '0);
        add_row(MODE_RGB, "rgb(-,1,2)", 0, '0);
        add_row(MODE_RGB, "rgb(,1,2)", 0, '0);
        add_row(MODE_RGB, "rgb(1,2", 0, '0);
        add_row(MODE_RGB, "rgb(1,", 0, '0);
        add_row(MODE_RGB, "rgb(1\011,2,3)", 0, '0);
        add_row(MODE_RGB, "rgb(1,2,3,4)", 0, '0);
        add_row(MODE_RGB, "rgba(1,2,3)", 0, '0);
        add_row(MODE_RGB, "rgb(1,2,3)tail", 0, '0);
        add_row(MODE_NONE, "#000000", 1, '0);
        add_row(MODE_NONE, "rgb(1,2,3)", 1, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 24;
        rx_idle_pct = 81;
        foreach (dir_text[i]) begin
            // the opening row runs on the reset format before any write
            if (i > 0 && dir_mode[i] != fmt_mode) set_format(dir_mode[i]);
            text_buf.delete();
            push_bytes(dir_text[i]);
            send_text();
            if (dir_typed[i]) colour_q[$] = dir_want[i];
        end

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 81 : 0;
            rx_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 24 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: set_format(MODE_HEX6);
                    3, 4, 5: set_format(MODE_HEX3);
                    6, 7, 8: set_format(MODE_RGB);
                    default: set_format(MODE_NONE);
                endcase
                sent = 0;
                while (sent < 100) begin
                    build_text(fmt_mode);
                    send_text();
                    sent += text_buf.size() + 1;
                end
            end
        end

        s_valid <= 1'b0;
        while (colour_q.size() != 0) @(posedge aclk);
        repeat (END_HOLD) @(posedge aclk);
        if (mismatches == 0 && colour_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
